// File: src/ceiling_texture_coordinate_caster_assert.svh
// assertion macros for the ceiling texture coordinate caster
// expects clk and arst_n in the scope of each use
`ifndef CEILING_TEXTURE_COORDINATE_CASTER_ASSERT_SVH
`define CEILING_TEXTURE_COORDINATE_CASTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CTC_ASSERT_ALWAYS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ctc check failed");
`define CTC_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctc check failed");
`define CTC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctc check failed");
`else
`define CTC_ASSERT_ALWAYS(name, cond)
`define CTC_ASSERT_IMPL(name, ante, cons)
`define CTC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: src/ctc_pkg.sv
// shared types and constants of the ceiling texture coordinate caster
// no dependencies
package ctc_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PLAYER_X      = 3'd0,
		REG_PLAYER_Y      = 3'd1,
		REG_PLAYER_ANGLE  = 3'd2,
		REG_FIELD_OF_VIEW = 3'd3,
		REG_HORIZON_ROW   = 3'd4,
		REG_SCREEN_WIDTH  = 3'd5,
		REG_SCREEN_HEIGHT = 3'd6
	} cfg_reg_t;

	// sine polynomial coefficients
	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [15:0] SIN_B = 16'd42047;
	localparam logic [12:0] SIN_C = 13'd4640;
	localparam logic [14:0] SIN_ONE = 15'd16384;

	// distance clamp, 20.0 in q5.11
	localparam logic [15:0] DIST_MAX = 16'd40960;

	// sideband through the offset divider
	typedef struct packed {
		logic        neg;
		logic [11:0] x;
		logic [11:0] y;
		logic [15:0] row;
	} div1_side_t;

	// sideband through the sine stages
	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [15:0] row;
	} sin_side_t;

	// sideband through the distance divider
	typedef struct packed {
		logic [11:0]        x;
		logic [11:0]        y;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic               sat;
	} div2_side_t;

	// one finished result
	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [5:0]  u;
		logic [5:0]  v;
		logic [15:0] ceil_dist;
	} res_t;

endpackage

// File: src/ctc_sin.sv
// four stage pipelined sine of a 16 bit turn angle, q1.14 result
// uses ctc_pkg for the polynomial coefficients
module ctc_sin (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        angle,
	output logic signed [15:0] sine
);

	logic [14:0] t_c;
	logic [29:0] sq_c;
	logic [14:0] t_s1, t2_s1;
	logic        neg_s1;

	logic [27:0] p_c;
	logic [15:0] inner_s2;
	logic [14:0] t_s2, t2_s2;
	logic        neg_s2;

	logic [30:0] pm_c;
	logic [16:0] mid_s3;
	logic [14:0] t_s3;
	logic        neg_s3;

	logic [31:0] pr_c;
	logic [15:0] s_c;
	logic [15:0] sc_c;

	// fold the quadrant onto 0..quarter turn
	assign t_c  = angle[14] ? (ctc_pkg::SIN_ONE - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign sq_c = {15'd0, t_c} * {15'd0, t_c};

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t_c;
			t2_s1  <= sq_c[28:14];
			neg_s1 <= angle[15];
		end
	end

	assign p_c = {13'd0, t2_s1} * {15'd0, ctc_pkg::SIN_C};

	always_ff @(posedge clk) begin
		if (en) begin
			inner_s2 <= ctc_pkg::SIN_B - {2'd0, p_c[27:14]};
			t_s2     <= t_s1;
			t2_s2    <= t2_s1;
			neg_s2   <= neg_s1;
		end
	end

	assign pm_c = {16'd0, t2_s2} * {15'd0, inner_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s3 <= ctc_pkg::SIN_A - {{16{1'b0}}, 1'b0} - 17'(pm_c[30:14]);
			t_s3   <= t_s2;
			neg_s3 <= neg_s2;
		end
	end

	assign pr_c = {17'd0, t_s3} * {15'd0, mid_s3};
	assign s_c  = pr_c[31:16];
	assign sc_c = (s_c > {1'b0, ctc_pkg::SIN_ONE}) ? {1'b0, ctc_pkg::SIN_ONE} : s_c;

	always_ff @(posedge clk) begin
		if (en) begin
			sine <= neg_s3 ? -$signed(sc_c) : $signed(sc_c);
		end
	end

endmodule

// File: src/ctc_div.sv
// pipelined restoring divider, one quotient bit per stage
// the caller guarantees the initial remainder is below the divisor
module ctc_div #(
	parameter int RW = 15,
	parameter int QW = 14,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          req_vld,
	input  logic [RW-1:0] rem_init,
	input  logic [QW-1:0] num_low,
	input  logic [RW-1:0] divisor,
	input  logic [SW-1:0] side,
	output logic          quo_vld,
	output logic [QW-1:0] quotient,
	output logic [SW-1:0] quo_side
);

	logic          vld_s  [QW];
	logic [RW-1:0] rem_s  [QW];
	logic [QW-1:0] bits_s [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [RW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic          v_in;
		logic [RW-1:0] r_in;
		logic [QW-1:0] b_in;
		logic [QW-1:0] q_in;
		logic [RW-1:0] d_in;
		logic [SW-1:0] s_in;
		logic [RW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in = req_vld;
			assign r_in = rem_init;
			assign b_in = num_low;
			assign q_in = '0;
			assign d_in = divisor;
			assign s_in = side;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign r_in = rem_s[k-1];
			assign b_in = bits_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
			assign s_in = side_s[k-1];
		end

		assign trial = {r_in, b_in[QW-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? RW'(trial - {1'b0, d_in}) : RW'(trial);
				bits_s[k] <= b_in << 1;
				quo_s[k]  <= QW'({q_in, ge});
				den_s[k]  <= d_in;
				side_s[k] <= s_in;
			end
		end
	end

	assign quo_vld  = vld_s[QW-1];
	assign quotient = quo_s[QW-1];
	assign quo_side = side_s[QW-1];

endmodule

// File: src/ceiling_texture_coordinate_caster.sv
// top level of the ceiling texture coordinate caster
// uses ctc_pkg, ctc_div, ctc_sin and the assertion macro header
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+------------------------------
//  in      | in_valid in_ready pixel_x pixel_y         | one pixel request
//  out     | out_valid out_ready out_x out_y tex_u     | one ceiling texel request
//          | tex_v distance                            |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | one register write, always ready
//
// one pixel enters per cycle while the output buffer is not full
// the pipe holds the two dividers (14 and 17 steps) and the 4 stage sine units
// pixels outside the ceiling band are dropped at the end of the first stage
// reset clears every valid bit and loads the register defaults; no clearing pass
// a stalled output fills a two entry output buffer; only a full buffer holds input
// texture size must be a power of two; the block itself does not enforce it

`include "ceiling_texture_coordinate_caster_assert.svh"

module ceiling_texture_coordinate_caster #(
	parameter int TEX_SIZE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] out_x,
	output logic [11:0] out_y,
	output logic [5:0]  tex_u,
	output logic [5:0]  tex_v,
	output logic [15:0] distance,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int TEX_BITS = $clog2(TEX_SIZE);
	localparam int SH       = 25 - TEX_BITS;
	localparam logic [24:0] BIAS = 25'((1 << SH) - 1);
	localparam int SIN_LAT  = 4;

	// configuration registers
	logic signed [19:0] player_x_q, player_y_q;
	logic [15:0]        player_angle_q;
	logic [14:0]        fov_q;
	logic signed [16:0] horizon_q;
	logic [12:0]        width_q, height_q;

	// global advance: the whole pipe moves unless the output buffer is full
	logic en;
	logic push;
	logic pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q     <= '0;
			player_y_q     <= '0;
			player_angle_q <= '0;
			fov_q          <= 15'd10923;
			horizon_q      <= 17'sd3840;
			width_q        <= 13'd320;
			height_q       <= 13'd480;
		end else if (cfg_valid) begin
			case (ctc_pkg::cfg_reg_t'(cfg_index))
				ctc_pkg::REG_PLAYER_X:      player_x_q     <= cfg_data;
				ctc_pkg::REG_PLAYER_Y:      player_y_q     <= cfg_data;
				ctc_pkg::REG_PLAYER_ANGLE:  player_angle_q <= cfg_data[15:0];
				ctc_pkg::REG_FIELD_OF_VIEW: fov_q          <= cfg_data[14:0];
				ctc_pkg::REG_HORIZON_ROW:   horizon_q      <= cfg_data[16:0];
				ctc_pkg::REG_SCREEN_WIDTH:  width_q        <= cfg_data[12:0];
				ctc_pkg::REG_SCREEN_HEIGHT: height_q       <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- stage 1
	logic        v_s1;
	logic [11:0] x_s1, y_s1;

	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
	end

	// ceiling band test, row distance, offset numerator
	logic               hpos_c;
	logic               in_band_c;
	logic signed [17:0] row_c;
	logic signed [13:0] diff_c;
	logic [13:0]        mag_c;
	logic [28:0]        num_c;
	logic               emit_c;

	assign hpos_c    = !horizon_q[16] && (horizon_q != '0);
	// band ends at the horizon truncated and clamped to the screen height
	assign in_band_c = hpos_c && (y_s1 < horizon_q[15:4]) && ({1'b0, y_s1} < height_q);
	assign row_c     = $signed({horizon_q[16], horizon_q}) - $signed({2'b00, y_s1, 4'b0000});
	assign emit_c    = ({1'b0, x_s1} < width_q) && in_band_c && (row_c > 18'sd16);
	assign diff_c    = $signed({1'b0, x_s1, 1'b0}) - $signed({1'b0, width_q});
	assign mag_c     = diff_c[13] ? 14'(-diff_c) : 14'(diff_c);
	assign num_c     = {15'd0, mag_c} * {14'd0, fov_q};

	// ---------------------------------------------------------------- stage 2
	logic        v_s2;
	logic [28:0] num_s2;
	ctc_pkg::div1_side_t side1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2       <= num_c;
			side1_s2.neg <= diff_c[13];
			side1_s2.x   <= x_s1;
			side1_s2.y   <= y_s1;
			side1_s2.row <= row_c[15:0];
		end
	end

	// offset divide by twice the width; quotient fits 14 bits for pixels on screen
	logic                v_d1;
	logic [13:0]         q_d1;
	logic [$bits(ctc_pkg::div1_side_t)-1:0] side_d1_raw;
	ctc_pkg::div1_side_t side_d1;

	ctc_div #(
		.RW (15),
		.QW (14),
		.SW ($bits(ctc_pkg::div1_side_t))
	) u_div_off (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.req_vld  (v_s2),
		.rem_init (num_s2[28:14]),
		.num_low  (num_s2[13:0]),
		.divisor  ({1'b0, width_q, 1'b0}),
		.side     (side1_s2),
		.quo_vld  (v_d1),
		.quotient (q_d1),
		.quo_side (side_d1_raw)
	);

	assign side_d1 = ctc_pkg::div1_side_t'(side_d1_raw);

	// signed offset and the three angles
	logic [15:0] off_c;
	logic [15:0] ray_c;

	assign off_c = side_d1.neg ? 16'(-{2'b00, q_d1}) : {2'b00, q_d1};
	assign ray_c = player_angle_q + off_c;

	// ---------------------------------------------------------------- stage 3
	logic        v_s3;
	logic [15:0] angc_s3, ray_s3, rayc_s3;
	ctc_pkg::sin_side_t sside_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angc_s3      <= off_c + 16'd16384;
			ray_s3       <= ray_c;
			rayc_s3      <= ray_c + 16'd16384;
			sside_s3.x   <= side_d1.x;
			sside_s3.y   <= side_d1.y;
			sside_s3.row <= side_d1.row;
		end
	end

	// sine units: cosine of the offset, cosine and sine of the ray
	logic signed [15:0] cos_off, ray_cos, ray_sin;

	ctc_sin u_sin_c (.clk(clk), .en(en), .angle(angc_s3), .sine(cos_off));
	ctc_sin u_sin_x (.clk(clk), .en(en), .angle(rayc_s3), .sine(ray_cos));
	ctc_sin u_sin_y (.clk(clk), .en(en), .angle(ray_s3),  .sine(ray_sin));

	// valid and sideband ride alongside the sine stages
	logic               sv_s  [SIN_LAT];
	ctc_pkg::sin_side_t sd_s  [SIN_LAT];

	for (genvar k = 0; k < SIN_LAT; k++) begin : g_sdly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[k] <= 1'b0;
			end else if (en) begin
				sv_s[k] <= (k == 0) ? v_s3 : sv_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[k] <= (k == 0) ? sside_s3 : sd_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	// ---------------------------------------------------------------- stage 8
	// denominator row * cos; non-positive cosine forces the clamp
	logic        v_s8;
	logic [30:0] den_s8;
	logic        cbad_s8;
	logic signed [15:0] rx_s8, ry_s8;
	logic [11:0] x_s8, y_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= sv_s[SIN_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s8  <= {15'd0, sd_s[SIN_LAT-1].row} * {16'd0, cos_off[14:0]};
			cbad_s8 <= cos_off[15] || (cos_off == '0);
			rx_s8   <= ray_cos;
			ry_s8   <= ray_sin;
			x_s8    <= sd_s[SIN_LAT-1].x;
			y_s8    <= sd_s[SIN_LAT-1].y;
		end
	end

	// height << 28 over den; quotient of 2^17 or more is caught up front
	logic [30:0]         hnum_c;
	ctc_pkg::div2_side_t side2_c;

	assign hnum_c      = {7'd0, height_q, 11'd0};
	assign side2_c.x   = x_s8;
	assign side2_c.y   = y_s8;
	assign side2_c.rx  = rx_s8;
	assign side2_c.ry  = ry_s8;
	assign side2_c.sat = cbad_s8 || (hnum_c >= den_s8);

	logic                v_d2;
	logic [16:0]         q_d2;
	logic [$bits(ctc_pkg::div2_side_t)-1:0] side_d2_raw;
	ctc_pkg::div2_side_t side_d2;

	ctc_div #(
		.RW (31),
		.QW (17),
		.SW ($bits(ctc_pkg::div2_side_t))
	) u_div_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.req_vld  (v_s8),
		.rem_init (hnum_c),
		.num_low  ('0),
		.divisor  (den_s8),
		.side     (side2_c),
		.quo_vld  (v_d2),
		.quotient (q_d2),
		.quo_side (side_d2_raw)
	);

	assign side_d2 = ctc_pkg::div2_side_t'(side_d2_raw);

	// ---------------------------------------------------------------- stage 9
	logic        v_s9;
	logic [15:0] dist_s9;
	logic signed [15:0] rx_s9, ry_s9;
	logic [11:0] x_s9, y_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_d2.sat || (q_d2 > {1'b0, ctc_pkg::DIST_MAX})) begin
				dist_s9 <= ctc_pkg::DIST_MAX;
			end else begin
				dist_s9 <= q_d2[15:0];
			end
			rx_s9 <= side_d2.rx;
			ry_s9 <= side_d2.ry;
			x_s9  <= side_d2.x;
			y_s9  <= side_d2.y;
		end
	end

	// ---------------------------------------------------------------- stage 10
	logic        v_s10;
	logic signed [32:0] px_s10, py_s10;
	logic [15:0] dist_s10;
	logic [11:0] x_s10, y_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s10   <= rx_s9 * $signed({1'b0, dist_s9});
			py_s10   <= ry_s9 * $signed({1'b0, dist_s9});
			dist_s10 <= dist_s9;
			x_s10    <= x_s9;
			y_s10    <= y_s9;
		end
	end

	// ---------------------------------------------------------------- stage 11
	// world point in q25: player * 2^17 + direction * distance
	logic        v_s11;
	logic signed [37:0] wx_s11, wy_s11;
	logic [15:0] dist_s11;
	logic [11:0] x_s11, y_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s11   <= $signed({player_x_q[19], player_x_q, 17'd0})
				+ $signed({{5{px_s10[32]}}, px_s10});
			wy_s11   <= $signed({player_y_q[19], player_y_q, 17'd0})
				+ $signed({{5{py_s10[32]}}, py_s10});
			dist_s11 <= dist_s10;
			x_s11    <= x_s10;
			y_s11    <= y_s10;
		end
	end

	// scale by texture size, truncate toward zero, wrap: low bits of the biased shift
	logic [24:0] tx_c, ty_c;
	ctc_pkg::res_t res_c;

	assign tx_c = wx_s11[24:0] + (wx_s11[37] ? BIAS : 25'd0);
	assign ty_c = wy_s11[24:0] + (wy_s11[37] ? BIAS : 25'd0);

	assign res_c.x         = x_s11;
	assign res_c.y         = y_s11;
	assign res_c.u         = 6'(tx_c[24:SH]);
	assign res_c.v         = 6'(ty_c[24:SH]);
	assign res_c.ceil_dist = dist_s11;

	// ---------------------------------------------------------------- output buffer
	logic          ov_q, sv_q;
	ctc_pkg::res_t out_q, skid_q;

	assign en   = !sv_q;
	assign push = en && v_s11;
	assign pop  = ov_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			if (!ov_q || pop) begin
				if (sv_q) begin
					ov_q <= 1'b1;
					sv_q <= 1'b0;
				end else begin
					ov_q <= push;
				end
			end else if (push) begin
				sv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || pop) begin
			if (sv_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_c;
			end
		end else if (push) begin
			skid_q <= res_c;
		end
	end

	assign out_valid = ov_q;
	assign out_x     = out_q.x;
	assign out_y     = out_q.y;
	assign tex_u     = out_q.u;
	assign tex_v     = out_q.v;
	assign distance  = out_q.ceil_dist;

	// ---------------------------------------------------------------- checks
	`CTC_ASSERT_IMPL(a_skid_needs_out, sv_q, ov_q)
	`CTC_ASSERT_IMPL(a_dist_clamped, ov_q, out_q.ceil_dist <= ctc_pkg::DIST_MAX)
	`CTC_ASSERT_NEXT(a_stall_fills_skid, push && ov_q && !out_ready, sv_q)
	`CTC_ASSERT_ALWAYS(a_ready_is_room, in_ready == !sv_q)

endmodule

// File: dv/tb_ceiling_texture_coordinate_caster.sv
// testbench for the ceiling texture coordinate caster: random and directed pixels
// checked against an in-bench integer predictor; depends on ctc_pkg and the block
`timescale 1ns / 1ps

module tb_ceiling_texture_coordinate_caster;

	localparam int TEX = 64;
	localparam int LATENCY = 43;
	localparam longint LIMIT = 2000000;

	typedef struct {
		logic [11:0] x;
		logic [11:0] y;
		logic [5:0]  u;
		logic [5:0]  v;
		logic [15:0] ceil_dist;
	} texel_t;

	// register shadow and expected-texel store
	class texel_scoreboard;
		logic [19:0] px, py;
		logic [15:0] ang;
		logic [14:0] fov;
		logic [16:0] hor;
		logic [12:0] wid, hgt;
		texel_t pending[$];
		int errors;

		function new();
			px = 20'd0; py = 20'd0; ang = 16'd0; fov = 15'd10923;
			hor = 17'd3840; wid = 13'd320; hgt = 13'd480;
			errors = 0;
		endfunction

		function void write_reg(ctc_pkg::cfg_reg_t idx, logic [19:0] d);
			case (idx)
				ctc_pkg::REG_PLAYER_X: begin
					px = d;
				end
				ctc_pkg::REG_PLAYER_Y: begin
					py = d;
				end
				ctc_pkg::REG_PLAYER_ANGLE: begin
					ang = d[15:0];
				end
				ctc_pkg::REG_FIELD_OF_VIEW: begin
					fov = d[14:0];
				end
				ctc_pkg::REG_HORIZON_ROW: begin
					hor = d[16:0];
				end
				ctc_pkg::REG_SCREEN_WIDTH: begin
					wid = d[12:0];
				end
				ctc_pkg::REG_SCREEN_HEIGHT: begin
					hgt = d[12:0];
				end
				default: ;
			endcase
		endfunction

		// sine of a turn angle in q1.14
		function longint sine(longint a);
			longint q, t, t2, inr, mid, s;
			a = a & 64'hFFFF;
			q = a >> 14;
			t = a & 64'h3FFF;
			if (q & 1) t = 16384 - t;
			t2 = (t * t) >>> 14;
			inr = 42047 - ((t2 * 4640) >>> 14);
			mid = 102944 - ((t2 * inr) >>> 14);
			s = (t * mid) >>> 16;
			if (s > 16384) s = 16384;
			return (q >= 2) ? -s : s;
		endfunction

		function logic [5:0] wrap(longint pos, longint dir, longint ceil_dist);
			longint w, q, m;
			w = pos * (longint'(1) << 17) + dir * ceil_dist;
			q = (w * TEX) / (longint'(1) << 25);
			m = q % TEX;
			if (m < 0) m += TEX;
			return m[5:0];
		endfunction

		// note an accepted pixel, queue a texel if it lies in the ceiling band
		function void note_pixel(logic [11:0] x, logic [11:0] y);
			longint h, band_end, row, off, c, ceil_dist, ray;
			texel_t t;
			h = longint'($signed(hor));
			if (x >= wid) return;
			band_end = (h <= 0) ? 0 : h / 16;
			if (band_end > hgt) band_end = hgt;
			if (longint'(y) >= band_end) return;
			row = h - 16 * longint'(y);
			if (row <= 16) return;
			off = ((2 * longint'(x) - longint'(wid)) * longint'(fov)) / (2 * longint'(wid));
			c = sine(off + 16384 + 65536);
			if (c <= 0) ceil_dist = 40960;
			else begin
				ceil_dist = (longint'(hgt) << 28) / (row * c);
				if (ceil_dist > 40960) ceil_dist = 40960;
			end
			ray = (longint'(ang) + off + 65536) & 64'hFFFF;
			t.x = x; t.y = y;
			t.u = wrap(longint'($signed(px)), sine(ray + 16384), ceil_dist);
			t.v = wrap(longint'($signed(py)), sine(ray), ceil_dist);
			t.ceil_dist = ceil_dist[15:0];
			pending.push_back(t);
		endfunction

		function void check_texel(texel_t got);
			texel_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected texel x=%0d y=%0d", got.x, got.y);
				return;
			end
			e = pending.pop_front();
			if (got.x !== e.x || got.y !== e.y || got.u !== e.u || got.v !== e.v
					|| got.ceil_dist !== e.ceil_dist) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp x=%0d y=%0d u=%0d v=%0d d=%0d got x=%0d y=%0d u=%0d v=%0d d=%0d",
						e.x, e.y, e.u, e.v, e.ceil_dist,
						got.x, got.y, got.u, got.v, got.ceil_dist);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [11:0] pixel_x, pixel_y, out_x, out_y;
	logic [5:0] tex_u, tex_v;
	logic [15:0] distance;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;

	texel_scoreboard sb;
	longint cycles;
	int idle_pct;  // zero during the stretch with no idling

	ceiling_texture_coordinate_caster #(.TEX_SIZE(TEX)) uut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// output side: random stalls, check every accepted texel
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_texel('{out_x, out_y, tex_u, tex_v, distance});
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// one pixel request; valid held until accepted, dropped by the next idle or drain
	task automatic send_pixel(logic [11:0] x, logic [11:0] y);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; pixel_x <= x; pixel_y <= y;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(x, y);
	endtask

	// one register write; valid stays up for a following write
	task automatic write_reg(ctc_pkg::cfg_reg_t idx, logic [19:0] d);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
	endtask

	// wait until the pipeline has drained, then let dropped pixels pass too
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_view(logic [19:0] x, logic [19:0] y, logic [15:0] a, logic [14:0] f,
			logic [16:0] h, logic [12:0] w, logic [12:0] ht);
		write_reg(ctc_pkg::REG_PLAYER_X, x);
		write_reg(ctc_pkg::REG_PLAYER_Y, y);
		write_reg(ctc_pkg::REG_PLAYER_ANGLE, {4'd0, a});
		write_reg(ctc_pkg::REG_FIELD_OF_VIEW, {5'd0, f});
		write_reg(ctc_pkg::REG_HORIZON_ROW, {3'd0, h});
		write_reg(ctc_pkg::REG_SCREEN_WIDTH, {7'd0, w});
		write_reg(ctc_pkg::REG_SCREEN_HEIGHT, {7'd0, ht});
		cfg_valid <= 0;
	endtask

	// random pixel, mostly inside the screen and above the horizon
	task automatic random_pixel();
		int w, band;
		w = (sb.wid == 0) ? 1 : ((sb.wid > 4096) ? 4096 : sb.wid);
		band = $signed(sb.hor) / 16;
		if (band < 1) band = 1;
		if (band > 4096) band = 4096;
		if ($urandom_range(9) < 8)
			send_pixel(12'($urandom_range(w - 1)), 12'($urandom_range(band - 1)));
		else
			send_pixel(12'($urandom), 12'($urandom));
	endtask

	initial begin
		sb = new();
		cycles = 0; idle_pct = 33;
		arst_n = 0; in_valid = 0; pixel_x = 0; pixel_y = 0; out_ready = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, edges of the band, off screen, extreme fields
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd319, 12'd0);
		send_pixel(12'd160, 12'd100);
		send_pixel(12'd160, 12'd238);   // row near horizon
		send_pixel(12'd160, 12'd239);   // row within one of the horizon
		send_pixel(12'd160, 12'd240);   // at the band end
		send_pixel(12'd320, 12'd10);    // column outside screen
		send_pixel(12'hFFF, 12'hFFF);
		drain();
		write_reg(ctc_pkg::cfg_reg_t'(3'd7), 20'hFFFFF);  // unknown index ignored
		cfg_valid <= 0;
		send_pixel(12'd5, 12'd5);
		drain();
		// extreme view: large screen, widest fov, far position, negative coordinates
		set_view(20'h7FFFF, 20'h80000, 16'hFFFF, 15'h7FFF, 17'h0FFFF, 13'd4096, 13'd4096);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd1);
		send_pixel(12'hAAA, 12'h555);
		send_pixel(12'h555, 12'hAAA);
		drain();
		// horizon negative, width zero, tiny height (clamps band)
		set_view(20'h80000, 20'h7FFFF, 16'd0, 15'd0, 17'h10000, 13'd0, 13'd1);
		send_pixel(12'd0, 12'd0);
		drain();
		set_view(20'h00100, 20'hFFF00, 16'h8000, 15'd1, 17'd4000, 13'd1, 13'd1);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd0);
		drain();

		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			set_view(20'($urandom), 20'($urandom), 16'($urandom), 15'($urandom),
				(ph % 3 == 0) ? 17'($urandom) : 17'($urandom_range(200, 8000)),
				(ph % 4 == 0) ? 13'($urandom) : 13'($urandom_range(8, 640)),
				(ph % 4 == 1) ? 13'($urandom) : 13'($urandom_range(8, 480)));
			idle_pct = (ph == 3) ? 0 : 33;
			for (int i = 0; i < 135; i++) random_pixel();
			drain();
		end
		idle_pct = 33;
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+src
src/ctc_pkg.sv
src/ctc_sin.sv
src/ctc_div.sv
src/ceiling_texture_coordinate_caster.sv
dv/tb_ceiling_texture_coordinate_caster.sv
